// ----- rtl/utf16_to_utf8_escaping_transcoder_macros.svh -----
// Assertion macros for the UTF-16 to UTF-8 transcoder.
`ifndef UTF16_TO_UTF8_ESCAPING_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_ESCAPING_TRANSCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during rst.
`define U16U8_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u16u8: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define U16U8_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u16u8: next-cycle check failed");
`else
`define U16U8_ASSERT_IMP(label, ante, cons)
`define U16U8_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/u16u8_pkg.sv -----
// Shared types, constants and entity tables for the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u16u8_pkg;

  localparam int CODE_UNIT_W = 16;
  localparam int BYTE_W      = 8;

  // Job queue between the classifier and the byte sequencer
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_IS_UTF8 = 1'b0,
    CFG_ESCAPE_ENABLE  = 1'b1
  } cfg_reg_t;

  // Top six bits of a high or low surrogate code unit
  localparam logic [5:0] SURR_HI_TAG = 6'b110110;
  localparam logic [5:0] SURR_LO_TAG = 6'b110111;

  typedef enum logic [2:0] {
    ESC_NONE,
    ESC_AMP,
    ESC_LT,
    ESC_GT,
    ESC_QUOT
  } esc_t;

  // "&amp;", "&lt;", "&gt;", "&quot;", zero padded
  localparam logic [0:5][7:0] ENT_AMP  = {8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00};
  localparam logic [0:5][7:0] ENT_LT   = {8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00};
  localparam logic [0:5][7:0] ENT_GT   = {8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00};
  localparam logic [0:5][7:0] ENT_QUOT = {8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B};

  // One queued unit of work: an optional flushed lone surrogate, then the main part
  typedef struct packed {
    logic             flush;
    logic [2:0][7:0]  fbytes;
    logic [3:0][7:0]  mbytes;
    esc_t             esc;
    logic             last;
    logic [3:0]       total;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] level;
  } q_stat_t;

  function automatic esc_t esc_of(input logic [7:0] b);
    esc_t e;
    case (b)
      8'h26:   e = ESC_AMP;
      8'h3C:   e = ESC_LT;
      8'h3E:   e = ESC_GT;
      8'h22:   e = ESC_QUOT;
      default: e = ESC_NONE;
    endcase
    return e;
  endfunction

  function automatic logic [2:0] entity_len(input esc_t e);
    logic [2:0] n;
    case (e)
      ESC_AMP:  n = 3'd5;
      ESC_LT:   n = 3'd4;
      ESC_GT:   n = 3'd4;
      ESC_QUOT: n = 3'd6;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] entity_byte(input esc_t e, input logic [2:0] pos);
    logic [7:0] b;
    case (e)
      ESC_AMP:  b = ENT_AMP[pos];
      ESC_LT:   b = ENT_LT[pos];
      ESC_GT:   b = ENT_GT[pos];
      ESC_QUOT: b = ENT_QUOT[pos];
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/u16u8_if.sv -----
// Valid/ready channel interfaces for code units in and bytes out.
`default_nettype none
interface u16u8_in_if import u16u8_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CODE_UNIT_W-1:0] code_unit;
  logic                   last_unit;

  modport source (output valid, code_unit, last_unit, input ready);
  modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

interface u16u8_out_if import u16u8_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              run_last;
  logic              string_end;

  modport source (output valid, out_byte, byte_valid, run_last, string_end, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, string_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/u16u8_front.sv -----
// Front end: accepts code units, tracks surrogate and NUL state, builds byte jobs.
`default_nettype none
module u16u8_front import u16u8_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    source_is_utf8,
  input  wire logic    escape_enable,
  u16u8_in_if.sink     unit_ch,
  input  wire q_stat_t q_stat,
  output logic         push,
  output job_t         job
);

  logic       stopped;
  logic       pending_valid;
  logic [9:0] pending_high;

  logic [15:0] cu;
  logic        last;
  logic        is_hi;
  logic        is_lo;
  logic        accept;
  logic        stop_set;
  logic        hold;
  logic        pair;
  logic        bmp;
  logic        flush;
  logic        single;
  logic [7:0]  sbyte;
  logic [2:0]  mlen;
  logic [2:0]  main_len;
  logic [3:0][7:0] mbytes;
  logic [20:0] pair_cp;
  esc_t        esc;

  assign cu      = unit_ch.code_unit;
  assign last    = unit_ch.last_unit;
  assign is_hi   = (cu[15:10] == SURR_HI_TAG);
  assign is_lo   = (cu[15:10] == SURR_LO_TAG);
  assign pair_cp = 21'h10000 + {1'b0, pending_high, cu[9:0]};

  assign unit_ch.ready = !q_stat.full;
  assign accept        = unit_ch.valid && unit_ch.ready;

  always_comb begin
    flush    = 1'b0;
    stop_set = 1'b0;
    hold     = 1'b0;
    pair     = 1'b0;
    bmp      = 1'b0;
    single   = 1'b0;
    sbyte    = 8'h00;
    mlen     = 3'd0;
    mbytes   = '0;
    esc      = ESC_NONE;

    if (!stopped) begin
      if (source_is_utf8) begin
        flush = pending_valid;
        if (cu[7:0] == 8'h00) begin
          stop_set = 1'b1;
        end else begin
          single = 1'b1;
          sbyte  = cu[7:0];
        end
      end else if (pending_valid && is_lo) begin
        pair = 1'b1;
      end else begin
        flush = pending_valid;
        if (cu == 16'h0000) begin
          stop_set = 1'b1;
        end else if (is_hi && !last) begin
          hold = 1'b1;
        end else begin
          bmp = 1'b1;
        end
      end
    end

    if (pair) begin
      mlen      = 3'd4;
      mbytes[0] = {5'b11110, pair_cp[20:18]};
      mbytes[1] = {2'b10, pair_cp[17:12]};
      mbytes[2] = {2'b10, pair_cp[11:6]};
      mbytes[3] = {2'b10, pair_cp[5:0]};
    end else if (bmp) begin
      if (cu < 16'h0080) begin
        single = 1'b1;
        sbyte  = cu[7:0];
      end else if (cu < 16'h0800) begin
        mlen      = 3'd2;
        mbytes[0] = {3'b110, cu[10:6]};
        mbytes[1] = {2'b10, cu[5:0]};
      end else begin
        mlen      = 3'd3;
        mbytes[0] = {4'b1110, cu[15:12]};
        mbytes[1] = {2'b10, cu[11:6]};
        mbytes[2] = {2'b10, cu[5:0]};
      end
    end

    if (single) begin
      esc = escape_enable ? esc_of(sbyte) : ESC_NONE;
      if (esc == ESC_NONE) begin
        mlen      = 3'd1;
        mbytes[0] = sbyte;
      end
    end
  end

  assign main_len = (esc != ESC_NONE) ? entity_len(esc) : mlen;

  // A flushed lone high surrogate always encodes as ED, A0|hi[9:6], 80|hi[5:0]
  always_comb begin
    job.flush     = flush;
    job.fbytes[0] = 8'hED;
    job.fbytes[1] = {4'b1010, pending_high[9:6]};
    job.fbytes[2] = {2'b10, pending_high[5:0]};
    job.mbytes    = mbytes;
    job.esc       = esc;
    job.last      = last;
    job.total     = (flush ? 4'd3 : 4'd0) + {1'b0, main_len};
  end

  // Silent non-final units leave no job behind
  assign push = accept && ((job.total != 4'd0) || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped       <= 1'b0;
      pending_valid <= 1'b0;
      pending_high  <= 10'd0;
    end else if (accept) begin
      if (last) begin
        stopped       <= 1'b0;
        pending_valid <= 1'b0;
        pending_high  <= 10'd0;
      end else begin
        if (stop_set) begin
          stopped <= 1'b1;
        end
        if (hold) begin
          pending_valid <= 1'b1;
          pending_high  <= cu[9:0];
        end else if (flush || pair) begin
          pending_valid <= 1'b0;
          pending_high  <= 10'd0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/u16u8_fifo.sv -----
// Short job queue between the front end and the byte sequencer.
`default_nettype none
module u16u8_fifo import u16u8_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output job_t      rd_job,
  output q_stat_t   stat
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QDEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QPTR_W'(1);
    end
    return n;
  endfunction

  assign rd_job     = mem[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign stat.level = count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/u16u8_back.sv -----
// Back end: walks the head job one byte per cycle into the output register, unless stalled.
`default_nettype none
module u16u8_back import u16u8_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire job_t    job,
  input  wire q_stat_t q_stat,
  output logic         pop,
  u16u8_out_if.source  byte_ch
);

  logic [3:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_end;

  logic       bare;
  logic       in_flush;
  logic [2:0] mpos;
  logic [7:0] cur_byte;
  logic       fin;
  logic       advance;

  assign bare     = (job.total == 4'd0);
  assign in_flush = job.flush && (idx < 4'd3);
  assign mpos     = 3'(idx - (job.flush ? 4'd3 : 4'd0));
  assign fin      = bare || (idx == job.total - 4'd1);
  assign advance  = !q_stat.empty && (!out_valid || byte_ch.ready);
  assign pop      = advance && fin;

  always_comb begin
    if (bare) begin
      cur_byte = 8'h00;
    end else if (in_flush) begin
      cur_byte = job.fbytes[idx[1:0]];
    end else if (job.esc != ESC_NONE) begin
      cur_byte = entity_byte(job.esc, mpos);
    end else begin
      cur_byte = job.mbytes[mpos[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      idx       <= fin ? 4'd0 : idx + 4'd1;
    end else if (byte_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold payload until the next transfer
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= cur_byte;
      byte_valid <= !bare;
      run_last   <= fin;
      string_end <= fin && job.last;
    end
  end

  assign byte_ch.valid      = out_valid;
  assign byte_ch.out_byte   = out_byte;
  assign byte_ch.byte_valid = byte_valid;
  assign byte_ch.run_last   = run_last;
  assign byte_ch.string_end = string_end;

endmodule
`default_nettype wire

// ----- rtl/utf16_to_utf8_escaping_transcoder.sv -----
// Top level of the UTF-16/UTF-8 to UTF-8 transcoder with XML entity escaping.
//
//   channel   dir  payload                                        transfer when
//   unit_ch   in   code_unit[15:0], last_unit                     valid && ready
//   byte_ch   out  out_byte[7:0], byte_valid, run_last, string_end valid && ready
//   cfg       in   cfg_index[0:0], cfg_data[0:0]                  cfg_we
//
// An input unit is taken by the front end and queued as a job; its bytes leave
// the output register one per cycle while byte_ch is ready, and a unit yields
// 1 to 9 bytes. A bare string end yields one record without data, and a silent
// unit takes its input but leaves no byte.
// A two-entry job queue lets the front keep accepting while the output is stalled.
// Synchronous reset clears the surrogate, NUL and config state.
`default_nettype none
module utf16_to_utf8_escaping_transcoder import u16u8_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  u16u8_in_if.sink                   unit_ch,
  u16u8_out_if.source                byte_ch
);

`include "utf16_to_utf8_escaping_transcoder_macros.svh"

  logic    source_is_utf8;
  logic    escape_enable;
  logic    push;
  logic    pop;
  job_t    wr_job;
  job_t    rd_job;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_is_utf8 <= 1'b0;
      escape_enable  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_IS_UTF8: source_is_utf8 <= cfg_data[0];
        CFG_ESCAPE_ENABLE:  escape_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  u16u8_front u_front (
    .clk            (clk),
    .rst            (rst),
    .source_is_utf8 (source_is_utf8),
    .escape_enable  (escape_enable),
    .unit_ch        (unit_ch),
    .q_stat         (q_stat),
    .push           (push),
    .job            (wr_job)
  );

  u16u8_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  u16u8_back u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (rd_job),
    .q_stat  (q_stat),
    .pop     (pop),
    .byte_ch (byte_ch)
  );

  // A record without data is only ever the bare string end marker
  `U16U8_ASSERT_IMP(a_bare_end, byte_ch.valid && !byte_ch.byte_valid,
                    byte_ch.string_end && byte_ch.run_last && (byte_ch.out_byte == 8'h00))
  `U16U8_ASSERT_IMP(a_end_closes_run, byte_ch.valid && byte_ch.string_end, byte_ch.run_last)
  `U16U8_ASSERT_IMP(a_queue_bound, 1'b1, q_stat.level <= QCNT_W'(QDEPTH))
  `U16U8_ASSERT_NXT(a_push_lands, push, !q_stat.empty)

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the UTF-16/UTF-8 to UTF-8 transcoder with XML escaping.
`timescale 1ns / 100ps

module tb_top;
  import u16u8_pkg::*;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [15:0] UNIT_NUL   = 16'h0000;
  localparam int unsigned SUPP_BASE  = 32'h10000;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;

  localparam int DRAIN_CYCLES    = 16;
  localparam int UNITS_PER_PHASE = 44;
  localparam int MAX_PRINTS      = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       run_last;
    logic       string_end;
  } byte_rec_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    steady;

  u16u8_in_if  unit_if ();
  u16u8_out_if byte_if ();

  utf16_to_utf8_escaping_transcoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .unit_ch   (unit_if),
    .byte_ch   (byte_if)
  );

  always #5 clk = ~clk;

  // Shadow of the transcoder state and its mode registers
  logic       mode_utf8   = 1'b0;
  logic       mode_escape = 1'b0;
  logic [9:0] held_high   = '0;
  logic       held_valid  = 1'b0;
  logic       nul_seen    = 1'b0;

  logic [7:0] unit_bytes[$];
  byte_rec_t  expected_bytes[$];

  int mismatches    = 0;
  int bytes_checked = 0;
  int units_sent    = 0;
  int strings_sent  = 0;
  int mode_writes   = 0;

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) unit_bytes.push_back(8'(s[i]));
  endfunction

  function automatic void push_char(input logic [7:0] b);
    if (mode_escape) begin
      case (b)
        CH_AMP:  push_text("&amp;");
        CH_LT:   push_text("&lt;");
        CH_GT:   push_text("&gt;");
        CH_QUOT: push_text("&quot;");
        default: unit_bytes.push_back(b);
      endcase
    end else begin
      unit_bytes.push_back(b);
    end
  endfunction

  function automatic void push_code_point(input int unsigned cp);
    if (cp < 32'h80) begin
      push_char(8'(cp));
    end else if (cp < 32'h800) begin
      push_char(8'(32'hC0 | (cp >> 6)));
      push_char(8'(32'h80 | (cp & 32'h3F)));
    end else if (cp < 32'h10000) begin
      push_char(8'(32'hE0 | (cp >> 12)));
      push_char(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      push_char(8'(32'h80 | (cp & 32'h3F)));
    end else begin
      push_char(8'(32'hF0 | ((cp >> 18) & 32'h07)));
      push_char(8'(32'h80 | ((cp >> 12) & 32'h3F)));
      push_char(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      push_char(8'(32'h80 | (cp & 32'h3F)));
    end
  endfunction

  // Emit a held high surrogate on its own
  function automatic void flush_held();
    if (held_valid) begin
      push_code_point(32'(HIGH_FIRST) | 32'(held_high));
      held_valid = 1'b0;
      held_high  = '0;
    end
  endfunction

  // Work out the bytes one accepted code unit yields and queue them
  function automatic void predict_unit(input logic [15:0] code, input logic last);
    byte_rec_t rec;
    unit_bytes.delete();
    if (!nul_seen) begin
      if (mode_utf8) begin
        flush_held();
        if (code[7:0] == 8'h00) nul_seen = 1'b1;
        else push_char(code[7:0]);
      end else if (held_valid && code >= LOW_FIRST && code <= LOW_LAST) begin
        push_code_point(SUPP_BASE + (32'(held_high) << 10) + 32'(code - LOW_FIRST));
        held_valid = 1'b0;
        held_high  = '0;
      end else begin
        flush_held();
        if (code == UNIT_NUL) begin
          nul_seen = 1'b1;
        end else if (code >= HIGH_FIRST && code <= HIGH_LAST && !last) begin
          held_high  = 10'(code - HIGH_FIRST);
          held_valid = 1'b1;
        end else begin
          push_code_point(32'(code));
        end
      end
    end
    if (last) begin
      nul_seen   = 1'b0;
      held_valid = 1'b0;
      held_high  = '0;
      if (unit_bytes.size() == 0) begin
        rec = '{8'h00, 1'b0, 1'b1, 1'b1};
        expected_bytes.push_back(rec);
        return;
      end
    end
    foreach (unit_bytes[k]) begin
      rec.data       = unit_bytes[k];
      rec.data_valid = 1'b1;
      rec.run_last   = (k == unit_bytes.size() - 1);
      rec.string_end = rec.run_last && last;
      expected_bytes.push_back(rec);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Sink side: random stalls unless in a steady stretch
  always @(posedge clk) begin
    byte_if.ready <= steady || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    byte_rec_t want;
    if (!rst && byte_if.valid && byte_if.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer, byte %02h", byte_if.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (byte_if.out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", byte_if.out_byte, want.data));
        if (byte_if.byte_valid !== want.data_valid)
          report_mismatch($sformatf("byte_valid %b, want %b", byte_if.byte_valid,
                                    want.data_valid));
        if (byte_if.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b (byte %02h)", byte_if.run_last,
                                    want.run_last, want.data));
        if (byte_if.string_end !== want.string_end)
          report_mismatch($sformatf("string_end %b, want %b (byte %02h)", byte_if.string_end,
                                    want.string_end, want.data));
      end
    end
  end

  task automatic send_unit(input logic [15:0] code, input logic last);
    if (!steady && $urandom_range(99) < 15) begin
      unit_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    unit_if.valid     <= 1'b1;
    unit_if.code_unit <= code;
    unit_if.last_unit <= last;
    @(posedge clk);
    while (!unit_if.ready) @(posedge clk);
    predict_unit(code, last);
    units_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_string(input logic [15:0] units[$]);
    foreach (units[i]) send_unit(units[i], i == units.size() - 1);
  endtask

  task automatic stop_sending();
    unit_if.valid <= 1'b0;
  endtask

  // Hold until every expected byte is out, then let the pipeline settle
  task automatic wait_drained();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_modes(input logic utf8, input logic esc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOURCE_IS_UTF8;
    cfg_data  <= utf8;
    @(posedge clk);
    cfg_index <= CFG_ESCAPE_ENABLE;
    cfg_data  <= esc;
    @(posedge clk);
    cfg_we      <= 1'b0;
    mode_utf8   = utf8;
    mode_escape = esc;
    mode_writes++;
  endtask

  function automatic logic [15:0] rand_ascii();
    case ($urandom_range(0, 7))
      0:       return {8'h00, CH_AMP};
      1:       return {8'h00, CH_LT};
      2:       return {8'h00, CH_GT};
      3:       return {8'h00, CH_QUOT};
      default: return 16'($urandom_range(1, 127));
    endcase
  endfunction

  function automatic logic [7:0] rand_utf8_byte();
    case ($urandom_range(0, 5))
      0:       return 8'(rand_ascii());
      1, 2:    return 8'($urandom_range(8'h80, 8'hFF));
      3:       return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
      default: return 8'($urandom_range(1, 127));
    endcase
  endfunction

  // Mostly well-formed text, with lone surrogates, raw noise and NULs mixed in
  task automatic random_string(input logic utf8);
    logic [15:0] units[$];
    int          n;
    n = $urandom_range(1, 7);
    while (units.size() < n) begin
      if (utf8) begin
        units.push_back({8'($urandom), rand_utf8_byte()});
      end else begin
        case ($urandom_range(0, 11))
          0, 1, 2: units.push_back(rand_ascii());
          3, 4:    units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
          5, 6:    units.push_back($urandom_range(1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                                     : 16'($urandom_range(16'hE000, 16'hFFFF)));
          7, 8: begin
            units.push_back(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
            units.push_back(16'($urandom_range(LOW_FIRST, LOW_LAST)));
          end
          9:       units.push_back(16'($urandom_range(HIGH_FIRST, LOW_LAST)));
          10:      units.push_back(16'($urandom));
          default: units.push_back(($urandom_range(3) == 0) ? UNIT_NUL : rand_ascii());
        endcase
      end
    end
    send_string(units);
  endtask

  task automatic test_utf16_ranges();
    logic [15:0] s[$];
    set_modes(1'b0, 1'b0);
    // one-, two- and three-byte boundaries
    s = '{16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    send_string(s);
    // smallest and largest surrogate pairs
    s = '{HIGH_FIRST, LOW_FIRST, HIGH_LAST, LOW_LAST};
    send_string(s);
    // lone low, high followed by a non-low, high on the final unit
    s = '{LOW_FIRST, HIGH_FIRST, 16'h0041, HIGH_LAST};
    send_string(s);
    // held high before a NUL, then a silent unit closes the string
    s = '{16'hD834, UNIT_NUL, 16'h0041};
    send_string(s);
    s = '{UNIT_NUL};
    send_string(s);
  endtask

  task automatic test_escaping();
    logic [15:0] s[$];
    stop_sending();
    wait_drained();
    set_modes(1'b0, 1'b1);
    s = '{{8'h00, CH_AMP}, {8'h00, CH_LT}, {8'h00, CH_GT}, {8'h00, CH_QUOT}};
    send_string(s);
    // flushed surrogate plus the longest entity
    s = '{HIGH_FIRST, {8'h00, CH_QUOT}};
    send_string(s);
  endtask

  task automatic test_utf8_passthrough();
    logic [15:0] s[$];
    stop_sending();
    wait_drained();
    set_modes(1'b1, 1'b1);
    // upper byte ignored; NUL byte under a nonzero upper byte stops output
    s = '{{8'hFF, CH_AMP}, 16'h80FF, 16'h1200, 16'h0041};
    send_string(s);
    // switch to UTF-8 while a high surrogate is held
    stop_sending();
    wait_drained();
    set_modes(1'b0, 1'b0);
    send_unit(16'hD801, 1'b0);
    stop_sending();
    wait_drained();
    set_modes(1'b1, 1'b0);
    send_unit(16'h0042, 1'b1);
  endtask

  task automatic test_random_strings();
    int   phase_start;
    bit   paused;
    logic utf8;
    logic esc;
    for (int phase = 0; phase < 5; phase++) begin
      stop_sending();
      wait_drained();
      case (phase)
        0:       begin utf8 = 1'b0; esc = 1'b0; end
        1:       begin utf8 = 1'b0; esc = 1'b1; end
        2:       begin utf8 = 1'b1; esc = 1'b1; end
        3:       begin utf8 = 1'b1; esc = 1'b0; end
        default: begin utf8 = 1'b0; esc = 1'b1; end
      endcase
      set_modes(utf8, esc);
      steady      = (phase == 0);
      phase_start = units_sent;
      paused      = 1'b0;
      while (units_sent - phase_start < UNITS_PER_PHASE) begin
        random_string(utf8);
        // drop valid mid-phase and let the output run dry
        if (phase == 1 && !paused && units_sent - phase_start > 25) begin
          stop_sending();
          wait_drained();
          paused = 1'b1;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SOURCE_IS_UTF8;
    cfg_data          = '0;
    unit_if.valid     = 1'b0;
    unit_if.code_unit = '0;
    unit_if.last_unit = 1'b0;
    byte_if.ready     = 1'b0;
    steady            = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_utf16_ranges();
    test_escaping();
    test_utf8_passthrough();
    test_random_strings();
    stop_sending();
    wait_drained();
    $display("Sent %0d code units in %0d strings across %0d mode settings.",
             units_sent, strings_sent, mode_writes);
    $display("Checked %0d output transfers; %0d mismatches.", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d transfers still outstanding.", expected_bytes.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
